FILE: sv/afd_pkg.sv
// Package for the ASCII-hex frame deframer: transaction types, configuration
// layout, status codes, frame positions and the hex digit decoder.
// No dependencies.
package afd_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  info_byte;
    logic [10:0] info_index;
    logic [2:0]  status;
    logic [7:0]  device_address;
    logic [7:0]  device_type;
    logic [7:0]  return_code;
    logic [11:0] payload_len;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  start_char;
    logic [7:0]  end_char;
    logic [7:0]  expected_version;
    logic [12:0] min_frame_len;
    logic [12:0] max_frame_len;
  } cfg_t;

  localparam int unsigned PADDR_W   = 5;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_START_CHAR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_CHAR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_VERSION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN     = 3'd4;

  localparam logic [7:0]  RST_START_CHAR  = 8'd126;
  localparam logic [7:0]  RST_END_CHAR    = 8'd13;
  localparam logic [7:0]  RST_EXP_VERSION = 8'd32;
  localparam logic [12:0] RST_MIN_LEN     = 13'd18;
  localparam logic [12:0] RST_MAX_LEN     = 13'd4113;

  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_VERSION  = 3'd1;
  localparam logic [2:0] STATUS_CHECKSUM = 3'd2;
  localparam logic [2:0] STATUS_LEN_CHK  = 3'd3;
  localparam logic [2:0] STATUS_FORMAT   = 3'd4;

  localparam logic KIND_INFO   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // character positions within a frame
  localparam int unsigned POS_VERSION    = 2;
  localparam int unsigned POS_ADDRESS    = 4;
  localparam int unsigned POS_TYPE       = 6;
  localparam int unsigned POS_RETURN     = 8;
  localparam int unsigned POS_LEN_HI     = 10;
  localparam int unsigned POS_LEN_LO     = 12;
  localparam int unsigned POS_INFO_FIRST = 14;
  localparam int unsigned POS_SUM_FIRST  = 6;
  localparam int unsigned RECENT_DEPTH   = 5;

  // non-hex characters decode as zero
  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      d = c[3:0] + 4'd9;
    end
    return d;
  endfunction

endpackage

FILE: sv/ascii_hex_frame_deframer_unit.sv
// A result is written into the result buffer and offered on out from there.
// Throughput: one character per cycle while in_stall_o is low; the frame state updates on each accepted character.
// A two-entry result buffer keeps input flowing while out is stalled, until both entries are full.
// Reset: configuration to defaults, frame state cleared, buffer empty.
// Depends on afd_pkg, afd_cfg_regs, afd_frame_core, afd_out_buf.
module ascii_hex_frame_deframer_unit import afd_pkg::*; #(
  parameter int unsigned POSITION_BITS = 13
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t      cfg;
  logic      in_accept;
  logic      res_valid;
  out_item_t res;
  logic      buf_full;

  assign in_stall_o = buf_full;
  assign in_accept  = in_valid_i & ~buf_full;

  afd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  afd_frame_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (in_accept),
    .item_i      (in_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  afd_out_buf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept & res_valid),
    .data_i  (res),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

endmodule

FILE: sv/afd_cfg_regs.sv
// APB-style configuration register file of the frame deframer.
// Depends on afd_pkg for the register layout and reset values.
module afd_cfg_regs import afd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t                 cfg_q;
  logic [CFG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_char       <= RST_START_CHAR;
      cfg_q.end_char         <= RST_END_CHAR;
      cfg_q.expected_version <= RST_EXP_VERSION;
      cfg_q.min_frame_len    <= RST_MIN_LEN;
      cfg_q.max_frame_len    <= RST_MAX_LEN;
    end else if (wr_en) begin
      case (idx)
        REG_START_CHAR:  cfg_q.start_char       <= pwdata[7:0];
        REG_END_CHAR:    cfg_q.end_char         <= pwdata[7:0];
        REG_EXP_VERSION: cfg_q.expected_version <= pwdata[7:0];
        REG_MIN_LEN:     cfg_q.min_frame_len    <= pwdata[12:0];
        REG_MAX_LEN:     cfg_q.max_frame_len    <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_START_CHAR:  prdata = PDATA_W'(cfg_q.start_char);
      REG_END_CHAR:    prdata = PDATA_W'(cfg_q.end_char);
      REG_EXP_VERSION: prdata = PDATA_W'(cfg_q.expected_version);
      REG_MIN_LEN:     prdata = PDATA_W'(cfg_q.min_frame_len);
      REG_MAX_LEN:     prdata = PDATA_W'(cfg_q.max_frame_len);
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: sv/afd_frame_core.sv
// Per-character frame state and decode: hex pairing, header capture,
// running character sum and the end-of-frame checks. Depends on afd_pkg.
module afd_frame_core import afd_pkg::*; #(
  parameter int unsigned POSITION_BITS = 13
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      accept_i,
  input  in_item_t  item_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  localparam int unsigned PW = POSITION_BITS;

  logic [PW-1:0] pos_q, pos_d;
  logic [15:0]   sum_q, sum_d;
  logic [7:0]    recent_q [RECENT_DEPTH];
  logic [7:0]    recent_d [RECENT_DEPTH];
  logic [7:0]    first_q, first_d;
  logic [3:0]    nib_q, nib_d;
  logic [7:0]    ver_q, ver_d;
  logic [7:0]    addr_q, addr_d;
  logic [7:0]    type_q, type_d;
  logic [7:0]    ret_q, ret_d;
  logic [15:0]   lw_q, lw_d;

  logic [7:0]    c;
  logic [3:0]    nib;
  logic [7:0]    byte_v;
  logic [PW-1:0] idx_full;
  logic          have_info;
  logic [16:0]   frame_len;
  logic [15:0]   got, chk_sum;
  logic [5:0]    nsum;
  logic [3:0]    lchk_sum;
  logic          fmt_err;
  logic [2:0]    status;

  always_comb begin
    c        = item_i.char_code;
    nib      = hex_digit(c);
    byte_v   = {nib_q, nib};
    idx_full = (pos_q - PW'(POS_INFO_FIRST)) >> 1;
    have_info = 1'b0;

    pos_d   = pos_q;
    sum_d   = sum_q;
    first_d = first_q;
    nib_d   = nib_q;
    ver_d   = ver_q;
    addr_d  = addr_q;
    type_d  = type_q;
    ret_d   = ret_q;
    lw_d    = lw_q;
    for (int i = 0; i < RECENT_DEPTH; i++) begin
      recent_d[i] = recent_q[i];
    end

    if (pos_q == '0) begin
      first_d = c;
    end else begin
      if (pos_q >= PW'(POS_SUM_FIRST)) begin
        sum_d = sum_q + 16'(recent_q[RECENT_DEPTH-1]);
      end
      if (pos_q[0]) begin
        nib_d = nib;
      end else if (pos_q == PW'(POS_VERSION)) begin
        ver_d = byte_v;
      end else if (pos_q == PW'(POS_ADDRESS)) begin
        addr_d = byte_v;
      end else if (pos_q == PW'(POS_TYPE)) begin
        type_d = byte_v;
      end else if (pos_q == PW'(POS_RETURN)) begin
        ret_d = byte_v;
      end else if (pos_q == PW'(POS_LEN_HI)) begin
        lw_d[15:8] = byte_v;
      end else if (pos_q == PW'(POS_LEN_LO)) begin
        lw_d[7:0] = byte_v;
      end else if (pos_q >= PW'(POS_INFO_FIRST)) begin
        have_info = 16'(idx_full) < 16'(lw_q[11:1]);
      end
    end

    // end-of-frame checks on the updated header and sum
    frame_len = 17'(pos_q) + 17'd1;
    got       = {hex_digit(recent_q[3]), hex_digit(recent_q[2]),
                 hex_digit(recent_q[1]), hex_digit(recent_q[0])};
    chk_sum   = got + sum_d;
    nsum      = 6'(lw_d[11:8]) + 6'(lw_d[7:4]) + 6'(lw_d[3:0]);
    lchk_sum  = lw_d[15:12] + nsum[3:0];
    fmt_err   = (frame_len < 17'(cfg_i.min_frame_len)) ||
                (frame_len > 17'(cfg_i.max_frame_len)) ||
                (first_d != cfg_i.start_char) || (c != cfg_i.end_char);
    if (fmt_err) begin
      status = STATUS_FORMAT;
    end else if (chk_sum != 16'd0) begin
      status = STATUS_CHECKSUM;
    end else if (lchk_sum != 4'd0) begin
      status = STATUS_LEN_CHK;
    end else if (ver_d != cfg_i.expected_version) begin
      status = STATUS_VERSION;
    end else begin
      status = STATUS_OK;
    end

    res_o = '0;
    if (item_i.end_of_string) begin
      res_valid_o          = 1'b1;
      res_o.result_kind    = KIND_STATUS;
      res_o.status         = status;
      res_o.device_address = addr_d;
      res_o.device_type    = type_d;
      res_o.return_code    = ret_d;
      res_o.payload_len    = lw_d[11:0];
    end else begin
      res_valid_o       = have_info;
      res_o.result_kind = KIND_INFO;
      res_o.info_byte   = byte_v;
      res_o.info_index  = 11'(idx_full);
    end

    if (item_i.end_of_string) begin
      pos_d   = '0;
      sum_d   = '0;
      first_d = '0;
      nib_d   = '0;
      ver_d   = '0;
      addr_d  = '0;
      type_d  = '0;
      ret_d   = '0;
      lw_d    = '0;
      for (int i = 0; i < RECENT_DEPTH; i++) begin
        recent_d[i] = '0;
      end
    end else begin
      for (int i = RECENT_DEPTH - 1; i > 0; i--) begin
        recent_d[i] = recent_q[i-1];
      end
      recent_d[0] = c;
      pos_d = (pos_q == '1) ? pos_q : pos_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      sum_q   <= '0;
      first_q <= '0;
      nib_q   <= '0;
      ver_q   <= '0;
      addr_q  <= '0;
      type_q  <= '0;
      ret_q   <= '0;
      lw_q    <= '0;
      for (int i = 0; i < RECENT_DEPTH; i++) begin
        recent_q[i] <= '0;
      end
    end else if (accept_i) begin
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      first_q <= first_d;
      nib_q   <= nib_d;
      ver_q   <= ver_d;
      addr_q  <= addr_d;
      type_q  <= type_d;
      ret_q   <= ret_d;
      lw_q    <= lw_d;
      for (int i = 0; i < RECENT_DEPTH; i++) begin
        recent_q[i] <= recent_d[i];
      end
    end
  end

endmodule

FILE: sv/afd_out_buf.sv
// Two-entry result buffer: a two-slot ring with read and write pointers, so a new
// character is taken while a result waits. Depends on afd_pkg.
module afd_out_buf import afd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t data_i,
  output logic      full_o,
  output logic      valid_o,
  input  logic      stall_i,
  output out_item_t data_o
);

  out_item_t  buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign pop     = valid_o & ~stall_i;
  assign data_o  = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: sv/afd_checker.sv
// Port-level assertions for the frame deframer, bound to the top level.
// Depends on afd_pkg and ascii_hex_frame_deframer_unit.
module afd_checker import afd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_eos_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.end_of_string && !out_valid_o) |=>
      (out_valid_o && out_data_o.result_kind == KIND_STATUS))
    else $error("end of string gave no status transaction");

  a_info_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.result_kind == KIND_INFO) |->
      (out_data_o.status == STATUS_OK && out_data_o.payload_len == 12'd0 &&
       out_data_o.device_address == 8'd0))
    else $error("info transaction carries status fields");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.result_kind == KIND_STATUS) |->
      (out_data_o.info_byte == 8'd0 && out_data_o.info_index == 11'd0))
    else $error("status transaction carries info fields");

endmodule

bind ascii_hex_frame_deframer_unit afd_checker u_afd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
